// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr))

// Checks that a condition is followed by another on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	`ASSERT_CLK(lbl, clk, rst_n, (pre) |=> (post))

`endif

// ===== hdl/sha256c_pkg.sv =====
// Types, constants and round functions of the SHA-256 compression core.
package sha256c_pkg;

	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 16;
	localparam int NUM_ROUNDS = 64;
	localparam int CHAIN_LEN  = 8;
	localparam int WCNT_W     = $clog2(NUM_WORDS);
	localparam int RCNT_W     = $clog2(NUM_ROUNDS);
	localparam int CIDX_W     = $clog2(CHAIN_LEN);
	localparam int OCNT_W     = $clog2(CHAIN_LEN + 1);

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_ROUND = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	typedef struct packed {
		logic              load_word;
		logic              init_chain;
		logic              start;
		logic              round;
		logic [RCNT_W-1:0] round_idx;
		logic              finish;
		logic              emit_load;
		logic              emit_shift;
	} cmd_t;

	function automatic word_t rotr(input word_t v, input int s);
		return (v >> s) | (v << (WORD_W - s));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic word_t majority(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

	function automatic word_t init_hash(input logic [CIDX_W-1:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_const(input logic [RCNT_W-1:0] idx);
		word_t r;
		case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/sha256c_if.sv =====
// Valid/ready channel interfaces for message words and digest words.
interface sha256c_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic        first_of_message;
	logic        last_of_message;

	modport source (output valid, msg_word, first_of_message, last_of_message, input ready);
	modport sink (input valid, msg_word, first_of_message, last_of_message, output ready);
endinterface

interface sha256c_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;

	modport source (output valid, digest_word, digest_last, input ready);
	modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ===== hdl/sha256c_ctrl.sv =====
// Controller: block word count, round sequencing and digest output count.
module sha256c_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                first_flag,
	input  logic                last_flag,
	output logic                in_ready,
	output logic                out_valid,
	output logic                out_last,
	input  logic                out_ready,
	output sha256c_pkg::cmd_t   cmd
);
	import sha256c_pkg::*;

	state_t              state_q, state_d;
	logic [WCNT_W-1:0]   word_cnt_q;
	logic [RCNT_W-1:0]   round_cnt_q;
	logic [OCNT_W-1:0]   out_cnt_q;
	logic                last_q;
	logic                accept;

	assign in_ready  = (state_q == ST_LOAD);
	assign accept    = in_valid && in_ready;
	assign out_valid = (out_cnt_q != '0);
	assign out_last  = (out_cnt_q == OCNT_W'(1));

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.round_idx  = round_cnt_q;
		cmd.emit_shift = out_valid && out_ready;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					cmd.load_word  = 1'b1;
					cmd.init_chain = (word_cnt_q == '0) && first_flag;
					if (word_cnt_q == WCNT_W'(NUM_WORDS - 1)) begin
						cmd.start = 1'b1;
						state_d   = ST_ROUND;
					end
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (round_cnt_q == RCNT_W'(NUM_ROUNDS - 1)) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!last_q || !out_valid) begin
					cmd.finish    = 1'b1;
					cmd.emit_load = last_q;
					state_d       = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			word_cnt_q  <= '0;
			round_cnt_q <= '0;
			out_cnt_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_word) begin
				word_cnt_q <= word_cnt_q + WCNT_W'(1);
			end
			if (cmd.start) begin
				round_cnt_q <= '0;
				last_q      <= last_flag;
			end else if (cmd.round) begin
				round_cnt_q <= round_cnt_q + RCNT_W'(1);
			end
			if (cmd.emit_load) begin
				out_cnt_q <= OCNT_W'(CHAIN_LEN);
			end else if (cmd.emit_shift) begin
				out_cnt_q <= out_cnt_q - OCNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/sha256c_dp.sv =====
// Datapath: schedule window, working variables, chaining value and digest buffer.
module sha256c_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256c_pkg::cmd_t   cmd,
	input  sha256c_pkg::word_t  msg_word,
	output sha256c_pkg::word_t  digest_word
);
	import sha256c_pkg::*;

	word_t w_q [NUM_WORDS];
	word_t v_q [CHAIN_LEN];
	word_t h_q [CHAIN_LEN];
	word_t d_q [CHAIN_LEN];
	word_t sum [CHAIN_LEN];
	word_t sched_w, win_in, t1, t2;

	assign sched_w = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	assign win_in  = cmd.load_word ? msg_word : sched_w;
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ round_const(cmd.round_idx) + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

	always_comb begin
		for (int i = 0; i < CHAIN_LEN; i++) begin
			sum[i] = h_q[i] + v_q[i];
		end
	end

	assign digest_word = d_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.round) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[NUM_WORDS-1] <= win_in;
		end
		if (cmd.start) begin
			for (int i = 0; i < CHAIN_LEN; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.emit_load) begin
			for (int i = 0; i < CHAIN_LEN; i++) begin
				d_q[i] <= sum[i];
			end
		end else if (cmd.emit_shift) begin
			for (int i = 0; i < CHAIN_LEN - 1; i++) begin
				d_q[i] <= d_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_LEN; i++) begin
				h_q[i] <= init_hash(CIDX_W'(i));
			end
		end else if (cmd.init_chain) begin
			for (int i = 0; i < CHAIN_LEN; i++) begin
				h_q[i] <= init_hash(CIDX_W'(i));
			end
		end else if (cmd.finish) begin
			for (int i = 0; i < CHAIN_LEN; i++) begin
				h_q[i] <= sum[i];
			end
		end
	end

endmodule

// ===== hdl/sha256_compression_core.sv =====
// Top level of the SHA-256 compression core.
//
//   channel     dir  payload                                        handshake
//   msg_in      in   msg_word, first_of_message, last_of_message    valid / ready
//   digest_out  out  digest_word, digest_last                       valid / ready
//
// A block takes 16 word items, one per cycle at most, then 64 rounds (one round
// per cycle in the datapath) and a final add into the chaining value.
// A last block loads eight digest items into an output buffer that drains while
// the next block comes in; a last block's final add waits while it holds items.
// Reset loads the initial hash and clears all counts; no item is lost on stalls.
`include "assert_macros.svh"

module sha256_compression_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sha256c_msg_if.sink          msg_in,
	sha256c_dig_if.source        digest_out
);
	import sha256c_pkg::*;

	cmd_t cmd;

	sha256c_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (msg_in.valid),
		.first_flag (msg_in.first_of_message),
		.last_flag  (msg_in.last_of_message),
		.in_ready   (msg_in.ready),
		.out_valid  (digest_out.valid),
		.out_last   (digest_out.digest_last),
		.out_ready  (digest_out.ready),
		.cmd        (cmd)
	);

	sha256c_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_word    (msg_in.msg_word),
		.digest_word (digest_out.digest_word)
	);

	`ASSERT_NEVER(a_no_input_in_rounds, clk, arst_n, cmd.round && msg_in.ready)
	`ASSERT_NEVER(a_emit_into_empty, clk, arst_n, cmd.emit_load && digest_out.valid)
	`ASSERT_NEXT(a_finish_reopens, clk, arst_n, cmd.finish, msg_in.ready)
	`ASSERT_NEXT(a_emit_full, clk, arst_n, cmd.emit_load,
		digest_out.valid && !digest_out.digest_last)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the SHA-256 compression core with a built-in hash predictor.
`timescale 1ns / 100ps

module tb;

	typedef sha256c_pkg::word_t word_t;

	typedef struct packed {
		word_t word;
		logic  msg_first;
		logic  msg_last;
		logic  drain_first;
	} msg_item_t;

	typedef struct packed {
		word_t word;
		logic  last;
	} digest_item_t;

	logic clk;
	logic arst_n;

	sha256c_msg_if msg ();
	sha256c_dig_if dig ();

	sha256_compression_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_in     (msg),
		.digest_out (dig)
	);

	word_t iv_tab[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	word_t k_tab[64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	word_t        hash_state[8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	word_t        block_buf[16];
	int unsigned  word_pos = 0;

	msg_item_t    pending_words[$];
	digest_item_t digest_expect[$];

	int unsigned  mismatches = 0;
	int unsigned  cycle_cnt = 0;
	int unsigned  send_gap = 0;
	int unsigned  recv_gap = 0;
	int unsigned  hold_left = 0;
	int unsigned  digest_words_seen = 0;
	bit           held_once = 0;

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		word_t sched[64];
		word_t v[8];
		word_t t1;
		word_t t2;
		word_t s0;
		word_t s1;
		for (int r = 0; r < 16; r++)
			sched[r] = block_buf[r];
		for (int r = 16; r < 64; r++) begin
			s0 = ror(sched[r-15], 7) ^ ror(sched[r-15], 18) ^ (sched[r-15] >> 3);
			s1 = ror(sched[r-2], 17) ^ ror(sched[r-2], 19) ^ (sched[r-2] >> 10);
			sched[r] = s1 + sched[r-7] + s0 + sched[r-16];
		end
		for (int k = 0; k < 8; k++)
			v[k] = hash_state[k];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[r] + sched[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			hash_state[k] = hash_state[k] + v[k];
	endfunction

	function automatic void absorb_word(input msg_item_t it);
		int unsigned pos;
		pos = word_pos;
		if (pos == 0 && it.msg_first) begin
			for (int k = 0; k < 8; k++)
				hash_state[k] = iv_tab[k];
		end
		block_buf[pos] = it.word;
		word_pos = (pos + 1) % 16;
		if (pos == 15) begin
			compress_block();
			if (it.msg_last) begin
				for (int k = 0; k < 8; k++)
					digest_expect.push_back('{word: hash_state[k], last: (k == 7)});
			end
		end
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if ((cycle_cnt / 256) % 3 == 0)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 11))
			0: return 32'h00000000;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h00000001;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_block(input bit first, input bit last, input bit noisy,
		input bit drain);
		msg_item_t it;
		for (int k = 0; k < 16; k++) begin
			it.word = pick_word();
			it.msg_first = (k == 0) ? first : (noisy && $urandom_range(0, 1));
			it.msg_last = (k == 15) ? last : (noisy && $urandom_range(0, 1));
			it.drain_first = drain && (k == 0);
			pending_words.push_back(it);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	always @(posedge clk or negedge arst_n) begin
		bit take;
		if (!arst_n) begin
			msg.valid <= 1'b0;
			msg.msg_word <= '0;
			msg.first_of_message <= 1'b0;
			msg.last_of_message <= 1'b0;
			send_gap = 0;
		end else begin
			take = msg.valid && msg.ready;
			if (take) begin
				absorb_word(pending_words.pop_front());
				send_gap = pick_gap();
			end
			if (msg.valid && !take) begin
			end else if (send_gap > 0) begin
				send_gap--;
				msg.valid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				msg.valid <= 1'b0;
			end else if (pending_words[0].drain_first && digest_expect.size() != 0) begin
				msg.valid <= 1'b0;
			end else begin
				msg.valid <= 1'b1;
				msg.msg_word <= pending_words[0].word;
				msg.first_of_message <= pending_words[0].msg_first;
				msg.last_of_message <= pending_words[0].msg_last;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		digest_item_t want;
		if (!arst_n) begin
			dig.ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (dig.valid && dig.ready) begin
				if (digest_expect.size() == 0) begin
					$error("digest item with no expected result: word %h last %b",
						dig.digest_word, dig.digest_last);
					mismatches++;
				end else begin
					want = digest_expect.pop_front();
					if (dig.digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, dig.digest_word);
						mismatches++;
					end
					if (dig.digest_last !== want.last) begin
						$error("digest_last: expected %b, got %b", want.last, dig.digest_last);
						mismatches++;
					end
				end
				digest_words_seen++;
				if (digest_words_seen == 24 && !held_once) begin
					held_once = 1;
					hold_left = 2000;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				dig.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				dig.ready <= 1'b0;
			end else begin
				dig.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap = pick_gap();
			end
		end
	end

	initial begin
		msg_item_t it;
		word_t     edge_words[8];
		int unsigned msg_cnt;
		int unsigned digests;
		int unsigned nblk;
		bit        broken;
		bit        first;
		bit        last;
		edge_words = '{32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
			32'h7fffffff, 32'hfffffffe, 32'h55555555, 32'haaaaaaaa};
		arst_n = 1'b0;

		// After reset the chain starts from the initial hash without a first flag;
		// stray first and last flags inside the block must be ignored.
		for (int k = 0; k < 16; k++) begin
			it.word = (k < 8) ? edge_words[k] : $urandom;
			it.msg_first = (k == 7);
			it.msg_last = (k == 9) || (k == 15);
			it.drain_first = 1'b0;
			pending_words.push_back(it);
		end

		msg_cnt = 0;
		digests = 1;
		while (pending_words.size() < 350 || digests < 10) begin
			nblk = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
			broken = (msg_cnt >= 6) && ($urandom_range(0, 5) == 0);
			for (int b = 0; b < nblk; b++) begin
				first = (b == 0) ? !(broken && $urandom_range(0, 1)) : (broken && $urandom_range(0, 1));
				last = (b == nblk - 1) ? !(broken && $urandom_range(0, 1))
					: (broken && $urandom_range(0, 1));
				if (last)
					digests++;
				add_block(first, last, $urandom_range(0, 3) == 0, msg_cnt == 6 && b == 0);
			end
			msg_cnt++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || digest_expect.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && digest_expect.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb failed");
		$finish;
	end

endmodule

// ===== sha256_compression_core.f =====
+incdir+hdl
hdl/sha256c_pkg.sv
hdl/sha256c_if.sv
hdl/sha256c_ctrl.sv
hdl/sha256c_dp.sv
hdl/sha256_compression_core.sv
test/tb.sv
